>>> design/blrf_pkg.sv
// ----------------------------------------------------------------------------
// Battery level report filter package
// Shared types, constants and register codes.
// ----------------------------------------------------------------------------
package blrf_pkg;

  // Conversion constants
  localparam int PCT_SHIFT   = 9;    // raw charge / 512
  localparam int PCT_W       = 16 - PCT_SHIFT;
  localparam int LEVEL_W     = 7;
  localparam int MV_W        = 13;
  localparam int MV_PROD_W   = 19;   // 16-bit raw times 5
  localparam int MV_MULT     = 5;
  localparam int MV_SHIFT    = 6;    // divide by 64
  localparam int LEVEL_MAX   = 100;
  localparam int RUN_W       = 3;
  localparam int ALERT_W     = 5;
  localparam int ALERT_CLAMP = 16;
  localparam int ALERT_BASE  = 32;
  localparam int COMP_W      = 8;
  localparam int WORD_W      = 16;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_ALERT_LEVEL_LIMIT = 3'd0,
    REG_SUSTAINED_LOW_MV  = 3'd1,
    REG_LOW_SAMPLE_COUNT  = 3'd2,
    REG_EMPTY_VOLTAGE_MV  = 3'd3,
    REG_EMPTY_LEVEL_BELOW = 3'd4,
    REG_BOOT_FLOOR_MV     = 3'd5
  } cfg_reg_t;

  // Classified sample from the front
  typedef struct packed {
    logic               err;
    logic [LEVEL_W-1:0] level;   // converted level, boot floor applied
    logic [MV_W-1:0]    mv;
    logic [COMP_W-1:0]  comp;
    logic               active;  // discharging and not booting
    logic               low;     // active and below sustained-low voltage
    logic               empty;   // active, below empty voltage, small level
  } sample_t;

  // Result item
  typedef struct packed {
    logic               stay_awake;
    logic [WORD_W-1:0]  alert_word;
    logic               alert_write;
    logic [MV_W-1:0]    cell_mv;
    logic [LEVEL_W-1:0] level_percent;
  } result_t;

endpackage

>>> design/battery_level_report_filter_unit.sv
// ----------------------------------------------------------------------------
// Battery level report filter unit
// Filters fuel-gauge samples into a reported charge level and alert words.
// ----------------------------------------------------------------------------
// One sample per clock is accepted and one result per sample is produced,
// sustained as long as the result side keeps up. A sample crosses the
// front (conversion to mV and percent, threshold compares) into a
// two-entry queue; the back takes it from the queue once the result
// register is free or being read, applies the low-run, empty and no-rise
// rules and loads the result register, which raises m_tvalid. The back
// updates its running state once for each sample that it takes. A stalled
// result side fills the queue, after which s_tready drops. Configuration
// registers sit on the APB port at byte address 4*index; write them only
// while no sample is in flight.
module battery_level_report_filter_unit (
  input  logic        clk,
  input  logic        rst,
  // sample stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] charge_raw, [31:16] voltage_raw, [39:32] comp_byte,
  // [40] is_charging, [41] in_boot, [47:42] zero
  input  logic [47:0] s_tdata,
  // [0] gauge_error
  input  logic [0:0]  s_tuser,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [6:0] level_percent, [19:7] cell_mv, [20] alert_write,
  // [36:21] alert_word, [37] stay_awake, [39:38] zero
  output logic [39:0] m_tdata,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import blrf_pkg::*;

  // configuration registers
  logic [ALERT_W-1:0] alert_level_limit;
  logic [MV_W-1:0]    sustained_low_mv;
  logic [RUN_W-1:0]   low_sample_count;
  logic [MV_W-1:0]    empty_voltage_mv;
  logic [LEVEL_W-1:0] empty_level_below;
  logic [MV_W-1:0]    boot_floor_mv;

  logic     cfg_write;
  cfg_reg_t cfg_sel;

  sample_t  front_sample;
  sample_t  queue_sample;
  logic     queue_full;
  logic     queue_not_empty;
  logic     back_take;
  result_t  result;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_sel   = cfg_reg_t'(paddr[4:2]);

  // Register write: addresses beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      alert_level_limit <= ALERT_W'(10);
      sustained_low_mv  <= MV_W'(3400);
      low_sample_count  <= RUN_W'(5);
      empty_voltage_mv  <= MV_W'(3500);
      empty_level_below <= LEVEL_W'(4);
      boot_floor_mv     <= MV_W'(3000);
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_ALERT_LEVEL_LIMIT: alert_level_limit <= pwdata[ALERT_W-1:0];
        REG_SUSTAINED_LOW_MV:  sustained_low_mv  <= pwdata[MV_W-1:0];
        REG_LOW_SAMPLE_COUNT:  low_sample_count  <= pwdata[RUN_W-1:0];
        REG_EMPTY_VOLTAGE_MV:  empty_voltage_mv  <= pwdata[MV_W-1:0];
        REG_EMPTY_LEVEL_BELOW: empty_level_below <= pwdata[LEVEL_W-1:0];
        REG_BOOT_FLOOR_MV:     boot_floor_mv     <= pwdata[MV_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read: return the zero-extended value.
  always_comb begin
    unique case (cfg_sel)
      REG_ALERT_LEVEL_LIMIT: prdata = {{(32-ALERT_W){1'b0}}, alert_level_limit};
      REG_SUSTAINED_LOW_MV:  prdata = {{(32-MV_W){1'b0}}, sustained_low_mv};
      REG_LOW_SAMPLE_COUNT:  prdata = {{(32-RUN_W){1'b0}}, low_sample_count};
      REG_EMPTY_VOLTAGE_MV:  prdata = {{(32-MV_W){1'b0}}, empty_voltage_mv};
      REG_EMPTY_LEVEL_BELOW: prdata = {{(32-LEVEL_W){1'b0}}, empty_level_below};
      REG_BOOT_FLOOR_MV:     prdata = {{(32-MV_W){1'b0}}, boot_floor_mv};
      default:               prdata = '0;
    endcase
  end

  // Accept a sample whenever the queue has room.
  assign s_tready = !queue_full;

  blrf_front u_front (
    .charge_raw        (s_tdata[15:0]),
    .voltage_raw       (s_tdata[31:16]),
    .comp_byte         (s_tdata[39:32]),
    .is_charging       (s_tdata[40]),
    .in_boot           (s_tdata[41]),
    .gauge_error       (s_tuser[0]),
    .sustained_low_mv  (sustained_low_mv),
    .empty_voltage_mv  (empty_voltage_mv),
    .empty_level_below (empty_level_below),
    .boot_floor_mv     (boot_floor_mv),
    .sample            (front_sample)
  );

  blrf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid && s_tready),
    .push_data (front_sample),
    .full      (queue_full),
    .pop       (back_take),
    .not_empty (queue_not_empty),
    .pop_data  (queue_sample)
  );

  blrf_back u_back (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (queue_not_empty),
    .in_sample         (queue_sample),
    .in_take           (back_take),
    .alert_level_limit (alert_level_limit),
    .low_sample_count  (low_sample_count),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .out_result        (result)
  );

  // Pack the result transaction, first field lowest.
  assign m_tdata = {2'b00, result.stay_awake, result.alert_word, result.alert_write,
                    result.cell_mv, result.level_percent};

endmodule

>>> design/blrf_front.sv
// ----------------------------------------------------------------------------
// Battery level report filter front
// Converts one sample and classifies it against the voltage thresholds.
// ----------------------------------------------------------------------------
module blrf_front (
  input  logic [15:0]                 charge_raw,
  input  logic [15:0]                 voltage_raw,
  input  logic [blrf_pkg::COMP_W-1:0] comp_byte,
  input  logic                        is_charging,
  input  logic                        in_boot,
  input  logic                        gauge_error,
  input  logic [blrf_pkg::MV_W-1:0]   sustained_low_mv,
  input  logic [blrf_pkg::MV_W-1:0]   empty_voltage_mv,
  input  logic [blrf_pkg::LEVEL_W-1:0] empty_level_below,
  input  logic [blrf_pkg::MV_W-1:0]   boot_floor_mv,
  output blrf_pkg::sample_t           sample
);
  import blrf_pkg::*;

  logic [MV_PROD_W-1:0] mv_prod;
  logic [MV_W-1:0]      mv;
  logic [PCT_W-1:0]     raw_pct;
  logic [LEVEL_W-1:0]   level;
  logic                 active;

  always_comb begin
    mv_prod = {{(MV_PROD_W-16){1'b0}}, voltage_raw} * MV_PROD_W'(MV_MULT);
    mv      = mv_prod[MV_PROD_W-1:MV_SHIFT];
    raw_pct = charge_raw[15:PCT_SHIFT];
    level   = (raw_pct > PCT_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : LEVEL_W'(raw_pct);
    // boot floor: a zero reading at a healthy voltage during boot, not charging, shows one percent
    if (in_boot && raw_pct == '0 && mv > boot_floor_mv && !is_charging) begin
      level = LEVEL_W'(1);
    end
    active = !in_boot && !is_charging;

    sample.err    = gauge_error;
    sample.level  = level;
    sample.mv     = mv;
    sample.comp   = comp_byte;
    sample.active = active;
    sample.low    = active && (mv < sustained_low_mv);
    sample.empty  = active && (mv < empty_voltage_mv) && (level < empty_level_below);
  end

endmodule

>>> design/blrf_queue.sv
// ----------------------------------------------------------------------------
// Battery level report filter queue
// Short FIFO of classified samples between front and back.
// ----------------------------------------------------------------------------
module blrf_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  blrf_pkg::sample_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output blrf_pkg::sample_t pop_data
);
  import blrf_pkg::*;

  sample_t           mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/blrf_back.sv
// ----------------------------------------------------------------------------
// Battery level report filter back
// Applies the running-state rules and holds the result register.
// ----------------------------------------------------------------------------
module blrf_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  blrf_pkg::sample_t             in_sample,
  output logic                          in_take,
  input  logic [blrf_pkg::ALERT_W-1:0]  alert_level_limit,
  input  logic [blrf_pkg::RUN_W-1:0]    low_sample_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output blrf_pkg::result_t             out_result
);
  import blrf_pkg::*;

  logic [RUN_W-1:0]   low_run;
  logic [RUN_W-1:0]   low_run_next;
  logic [LEVEL_W-1:0] prior_level;
  logic [LEVEL_W-1:0] prior_level_next;
  logic [ALERT_W-1:0] alert_level;
  logic [ALERT_W-1:0] alert_level_next;
  result_t            result_next;
  logic [LEVEL_W-1:0] level;
  logic [ALERT_W-1:0] thr;
  logic [COMP_W-1:0]  thr_byte;
  logic               wr;

  assign in_take = in_valid && (!out_valid || out_ready);

  always_comb begin
    low_run_next     = low_run;
    prior_level_next = prior_level;
    alert_level_next = alert_level;
    level            = in_sample.level;
    thr              = '0;
    thr_byte         = '0;
    wr               = 1'b0;

    if (in_sample.low) begin
      low_run_next = (low_run == {RUN_W{1'b1}}) ? low_run : low_run + 1'b1;
    end else begin
      low_run_next = '0;
    end

    // force empty on a sustained low run or a small level at low voltage
    if ((in_sample.low && low_run_next >= low_sample_count) || in_sample.empty) begin
      level = '0;
    end

    // hold the level from rising while discharging
    if (in_sample.active && prior_level < level) begin
      level = prior_level;
    end else begin
      prior_level_next = level;
    end

    if (level <= LEVEL_W'(alert_level_limit) && level != '0 &&
        level != LEVEL_W'(alert_level)) begin
      thr              = (level > LEVEL_W'(ALERT_CLAMP)) ? ALERT_W'(ALERT_CLAMP)
                                                         : ALERT_W'(level);
      thr_byte         = COMP_W'(ALERT_BASE) - {{(COMP_W-ALERT_W-1){1'b0}}, thr, 1'b0};
      alert_level_next = thr;
      wr               = 1'b1;
    end

    result_next.level_percent = level;
    result_next.cell_mv       = in_sample.mv;
    result_next.alert_write   = wr;
    result_next.alert_word    = wr ? {thr_byte, in_sample.comp} : '0;
    result_next.stay_awake    = (level == '0);

    // a failed gauge read reports one percent and leaves state alone
    if (in_sample.err) begin
      low_run_next     = low_run;
      prior_level_next = prior_level;
      alert_level_next = alert_level;
      result_next      = '0;
      result_next.level_percent = LEVEL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_run     <= '0;
      prior_level <= '0;
      alert_level <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (in_take) begin
        low_run     <= low_run_next;
        prior_level <= prior_level_next;
        alert_level <= alert_level_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_result <= result_next;
    end
  end

endmodule

>>> tb/sv/blrf_report_checker.sv
// ----------------------------------------------------------------------------
// Battery level report checker
// Watches the sample, report and register channels of the filter, keeps its
// own model of the filter state and compares every report field by field.
// ----------------------------------------------------------------------------
module blrf_report_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // [15:0] charge_raw, [31:16] voltage_raw, [39:32] comp_byte,
  // [40] is_charging, [41] in_boot, [47:42] zero
  input  logic [47:0] s_tdata,
  // [0] gauge_error
  input  logic [0:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // [6:0] level_percent, [19:7] cell_mv, [20] alert_write,
  // [36:21] alert_word, [37] stay_awake, [39:38] zero
  input  logic [39:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          reports
);
  timeunit 1ns;
  timeprecision 1ps;
  import blrf_pkg::*;

  localparam int SHOW_LIMIT = 10;

  // Register copies
  logic [ALERT_W-1:0] cfg_alert_limit;
  logic [MV_W-1:0]    cfg_sustained_mv;
  logic [RUN_W-1:0]   cfg_low_count;
  logic [MV_W-1:0]    cfg_empty_mv;
  logic [LEVEL_W-1:0] cfg_empty_below;
  logic [MV_W-1:0]    cfg_boot_mv;

  // Filter state copies
  logic [RUN_W-1:0]   run_len;
  logic [LEVEL_W-1:0] held_level;
  logic [ALERT_W-1:0] alert_thr;

  result_t expected_reports[$];

  // Filter one sample and advance the state copies.
  function automatic result_t filter_sample(input logic [47:0] d, input logic gerr);
    logic [15:0]        charge;
    logic [15:0]        vraw;
    logic [7:0]         comp;
    logic               chg;
    logic               boot;
    logic               active;
    logic               low_v;
    logic [6:0]         raw_pct;
    logic [LEVEL_W-1:0] lvl;
    logic [18:0]        prod;
    logic [MV_W-1:0]    mv;
    logic [ALERT_W-1:0] thr;
    result_t            r;
    charge = d[15:0];
    vraw   = d[31:16];
    comp   = d[39:32];
    chg    = d[40];
    boot   = d[41];
    r      = '0;
    if (gerr) begin
      r.level_percent = 7'd1;
      return r;
    end
    raw_pct = charge[15:9];
    lvl     = (raw_pct > 7'd100) ? 7'd100 : raw_pct;
    prod    = 19'(vraw) * 19'd5;
    mv      = prod[18:6];
    if (boot && raw_pct == 7'd0 && mv > cfg_boot_mv && !chg) lvl = 7'd1;
    active = !boot && !chg;
    low_v  = active && (mv < cfg_sustained_mv);
    if (low_v) begin
      if (run_len != 3'd7) run_len = run_len + 3'd1;
    end else begin
      run_len = '0;
    end
    if (low_v && run_len >= cfg_low_count) lvl = '0;
    if (active && mv < cfg_empty_mv && lvl < cfg_empty_below) lvl = '0;
    // No rise while discharging
    if (active && held_level < lvl) lvl = held_level;
    else held_level = lvl;
    if (lvl <= cfg_alert_limit && lvl != '0 && lvl != {2'b00, alert_thr}) begin
      thr = (lvl > 7'd16) ? 5'd16 : lvl[4:0];
      r.alert_write = 1'b1;
      r.alert_word  = {8'(32 - 2 * int'(thr)), comp};
      alert_thr     = thr;
    end
    r.level_percent = lvl;
    r.cell_mv       = mv;
    r.stay_awake    = (lvl == '0);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      cfg_alert_limit  = 5'd10;
      cfg_sustained_mv = 13'd3400;
      cfg_low_count    = 3'd5;
      cfg_empty_mv     = 13'd3500;
      cfg_empty_below  = 7'd4;
      cfg_boot_mv      = 13'd3000;
      run_len          = '0;
      held_level       = '0;
      alert_thr        = '0;
      expected_reports.delete();
      fail_count       = 0;
      reports          = 0;
      pending          = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_ALERT_LEVEL_LIMIT: cfg_alert_limit  = pwdata[ALERT_W-1:0];
          REG_SUSTAINED_LOW_MV:  cfg_sustained_mv = pwdata[MV_W-1:0];
          REG_LOW_SAMPLE_COUNT:  cfg_low_count    = pwdata[RUN_W-1:0];
          REG_EMPTY_VOLTAGE_MV:  cfg_empty_mv     = pwdata[MV_W-1:0];
          REG_EMPTY_LEVEL_BELOW: cfg_empty_below  = pwdata[LEVEL_W-1:0];
          REG_BOOT_FLOOR_MV:     cfg_boot_mv      = pwdata[MV_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[37:0]);
        if (expected_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT)
            $display("tb: report with no sample outstanding: level %0d mv %0d",
                     got.level_percent, got.cell_mv);
        end else begin
          want = expected_reports.pop_front();
          reports++;
          if (got.level_percent !== want.level_percent ||
              got.cell_mv !== want.cell_mv ||
              got.alert_write !== want.alert_write ||
              got.alert_word !== want.alert_word ||
              got.stay_awake !== want.stay_awake ||
              m_tdata[39:38] !== 2'b00) begin
            fail_count++;
            if (fail_count <= SHOW_LIMIT) begin
              $display("tb: report %0d mismatch: expected lvl %0d mv %0d wr %0b word %h awake %0b",
                       reports, want.level_percent, want.cell_mv, want.alert_write,
                       want.alert_word, want.stay_awake);
              $display("tb:   got lvl %0d mv %0d wr %0b word %h awake %0b pad %b",
                       got.level_percent, got.cell_mv, got.alert_write, got.alert_word,
                       got.stay_awake, m_tdata[39:38]);
            end
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_reports.push_back(filter_sample(s_tdata, s_tuser[0]));
      pending = expected_reports.size();
    end
  end

endmodule

>>> tb/sv/battery_level_report_filter_unit_tb.sv
// ----------------------------------------------------------------------------
// Battery level report filter testbench
// Drives gauge samples and register settings into the filter with random
// gaps and back-pressure; a checker beside the filter predicts and compares
// every report.
// ----------------------------------------------------------------------------
module battery_level_report_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import blrf_pkg::*;

  typedef enum int {MODE_LOW_RUN, MODE_CHARGE_UP, MODE_MIXED} stim_mode_t;

  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 104;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;
  logic [0:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [4:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int reports;
  int samples_sent = 0;
  int settings_run = 1;
  bit calm         = 1'b0;   // no idling on either side
  int sust_now     = 3400;   // current sustained-low voltage, steers low runs

  always #10 clk = ~clk;

  battery_level_report_filter_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  blrf_report_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending),
    .reports    (reports)
  );

  // Stall the report side about 12 percent of the time, never while calm.
  always @(posedge clk) m_tready <= calm || ($urandom_range(99) >= 12);

  // Assemble one sample word in the tdata layout.
  function automatic logic [47:0] pack_sample(logic [15:0] charge, logic [15:0] vraw,
                                              logic [7:0] comp, logic chg, logic boot);
    return {6'b0, boot, chg, comp, vraw, charge};
  endfunction

  // Smallest raw voltage word that converts to exactly mv millivolts.
  function automatic logic [15:0] raw_for_mv(int mv);
    return 16'((mv * 64 + 4) / 5);
  endfunction

  // Build one random sample; bit 48 carries the gauge error flag.
  function automatic logic [48:0] random_sample(stim_mode_t m);
    logic [15:0] charge;
    logic [15:0] vraw;
    logic [7:0]  comp;
    logic        chg;
    logic        boot;
    logic        err;
    comp = 8'($urandom);
    case (m)
      MODE_LOW_RUN: begin
        // Discharging below the sustained-low voltage: builds the low run
        chg    = 1'b0;
        boot   = 1'b0;
        err    = ($urandom_range(99) < 3);
        charge = 16'($urandom);
        vraw   = (sust_now > 0) ? raw_for_mv($urandom_range(0, sust_now - 1))
                                : 16'($urandom);
      end
      MODE_CHARGE_UP: begin
        // Charging lifts the held level again
        chg    = 1'b1;
        boot   = ($urandom_range(99) < 10);
        err    = ($urandom_range(99) < 3);
        charge = 16'($urandom);
        vraw   = raw_for_mv($urandom_range(2500, 4500));
      end
      default: begin
        chg  = ($urandom_range(99) < 30);
        boot = ($urandom_range(99) < 15);
        err  = ($urandom_range(99) < 5);
        if ($urandom_range(3) == 0) vraw = 16'($urandom);
        else vraw = raw_for_mv($urandom_range(2500, 4500));
        case ($urandom_range(3))
          0:       charge = 16'($urandom);
          1:       charge = 16'($urandom_range(0, 511));
          default: charge = 16'($urandom_range(0, 20 * 512 + 511));
        endcase
      end
    endcase
    return {err, pack_sample(charge, vraw, comp, chg, boot)};
  endfunction

  // Offer one sample and hold it until the filter takes the transaction.
  task automatic send_sample(input logic [47:0] d, input logic err);
    if (!calm) begin
      while ($urandom_range(99) < 12) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= err;
    do @(posedge clk); while (!s_tready);
    samples_sent++;
  endtask

  // Drop valid and hold until every expected report has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_setting(input int limit, input int sust, input int cnt,
                               input int empty_mv, input int below, input int boot_mv);
    write_reg(REG_ALERT_LEVEL_LIMIT, 32'(limit));
    write_reg(REG_SUSTAINED_LOW_MV, 32'(sust));
    write_reg(REG_LOW_SAMPLE_COUNT, 32'(cnt));
    write_reg(REG_EMPTY_VOLTAGE_MV, 32'(empty_mv));
    write_reg(REG_EMPTY_LEVEL_BELOW, 32'(below));
    write_reg(REG_BOOT_FLOOR_MV, 32'(boot_mv));
    sust_now = sust;
    settings_run++;
  endtask

  initial begin
    int         left_in_mode;
    stim_mode_t mode;
    logic [48:0] smp;
    left_in_mode = 0;
    mode         = MODE_MIXED;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed samples under the reset register values.
    // Discharging before any level is held: reports zero.
    send_sample(pack_sample(16'(50 * 512), raw_for_mv(4000), 8'h00, 1'b0, 1'b0), 1'b0);
    // Full-scale charge and voltage while charging: capped at 100, 5119 mV
    send_sample(pack_sample(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b0), 1'b0);
    send_sample(pack_sample(16'hFFFF, raw_for_mv(4000), 8'h5A, 1'b0, 1'b0), 1'b0);
    send_sample(pack_sample(16'(60 * 512), raw_for_mv(3900), 8'h11, 1'b0, 1'b0), 1'b0);
    // Gauge error with every data bit set: fixed report, state untouched
    send_sample(pack_sample(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1), 1'b1);
    // Boot floor: zero percent above the floor voltage reads one
    send_sample(pack_sample(16'd300, raw_for_mv(3100), 8'hA5, 1'b0, 1'b1), 1'b0);
    send_sample(pack_sample(16'd511, raw_for_mv(2900), 8'h0F, 1'b0, 1'b1), 1'b0);
    send_sample(pack_sample(16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0), 1'b0);
    // Walk through the alert window edges while charging
    send_sample(pack_sample(16'(5 * 512), raw_for_mv(4100), 8'h3C, 1'b1, 1'b0), 1'b0);
    send_sample(pack_sample(16'(9 * 512), raw_for_mv(4100), 8'hC3, 1'b1, 1'b0), 1'b0);
    send_sample(pack_sample(16'(10 * 512), raw_for_mv(4100), 8'h81, 1'b1, 1'b0), 1'b0);
    send_sample(pack_sample(16'(11 * 512), raw_for_mv(4100), 8'h7E, 1'b1, 1'b0), 1'b0);
    send_sample(pack_sample(16'(80 * 512), raw_for_mv(4100), 8'h42, 1'b1, 1'b0), 1'b0);
    // Sustained low run long enough to force zero and saturate the counter
    repeat (9)
      send_sample(pack_sample(16'(70 * 512), raw_for_mv(3300), 8'h24, 1'b0, 1'b0), 1'b0);
    // Small level at low voltage reads empty
    send_sample(pack_sample(16'(3 * 512), raw_for_mv(4000), 8'h99, 1'b1, 1'b0), 1'b0);
    send_sample(pack_sample(16'(3 * 512), raw_for_mv(3450), 8'h66, 1'b0, 1'b0), 1'b0);
    send_sample(pack_sample(16'(3 * 512), raw_for_mv(3600), 8'h33, 1'b0, 1'b0), 1'b0);
    wait_drained();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: apply_setting(16, 5119, 7, 5119, 100, 5119);
        1: apply_setting(1, 0, 1, 0, 0, 0);
        // Zero sample count and an alert limit above sixteen
        2: apply_setting(31, 3600, 0, 3700, 20, 3000);
        3: apply_setting(10, 3400, 5, 3500, 4, 3000);
        default: apply_setting(($urandom_range(3) == 0) ? $urandom_range(17, 31)
                                                        : $urandom_range(1, 16),
                               $urandom_range(2800, 4300), $urandom_range(0, 7),
                               $urandom_range(3000, 4200), $urandom_range(0, 30),
                               $urandom_range(2500, 3800));
      endcase
      // One whole phase runs without idling on either side
      calm = (ph == 3);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (left_in_mode == 0) begin
          case ($urandom_range(3))
            0:       mode = MODE_LOW_RUN;
            1:       mode = MODE_CHARGE_UP;
            default: mode = MODE_MIXED;
          endcase
          left_in_mode = $urandom_range(1, 12);
        end
        left_in_mode--;
        // Hold off mid-phase once until the pipeline is empty
        if (ph == 5 && k == PHASE_ITEMS / 2) wait_drained();
        smp = random_sample(mode);
        send_sample(smp[47:0], smp[48]);
      end
      wait_drained();
    end
    calm = 1'b0;

    repeat (8) @(posedge clk);
    $display("tb: %0d samples sent under %0d register settings, %0d reports checked",
             samples_sent, settings_run, reports);
    $display("tb: %0d mismatching reports, %0d still outstanding", fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
